### rtl/fmpf_pkg.sv
// ----------------------------------------------------------------------------
// fmpf_pkg: first-match packet filter shared definitions
// Rule layout, command codes, status codes and cell control for the filter.
// ----------------------------------------------------------------------------
package fmpf_pkg;

  localparam int MAX_RULES = 16;
  localparam int CNT_W     = $clog2(MAX_RULES + 1);
  localparam int IDX_W     = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

  localparam int IN_W  = 128;
  localparam int OUT_W = 40;

  localparam logic [2:0] OP_CHECK  = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_UPDATE = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;
  localparam logic [2:0] OP_SETID  = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  localparam logic [1:0] CELL_HOLD  = 2'd0;
  localparam logic [1:0] CELL_LOAD  = 2'd1;
  localparam logic [1:0] CELL_SHIFT = 2'd2;
  localparam logic [1:0] CELL_CLEAR = 2'd3;

  localparam logic [15:0] ID_RESET = 16'd1;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] sip;
    logic        sip_any;
    logic [31:0] dip;
    logic        dip_any;
    logic [1:0]  proto;
    logic [15:0] sport;
    logic [15:0] dport;
    logic        allow;
    logic        enabled;
  } rule_t;

  typedef struct packed {
    logic [1:0] cmd;
  } cell_ctl_t;

endpackage

### rtl/fmpf_cell.sv
// ----------------------------------------------------------------------------
// fmpf_cell: one rule slot of the filter chain
// Holds one rule, compares it against the broadcast query and takes its
// upper neighbor's rule when the table closes a gap.
// ----------------------------------------------------------------------------
module fmpf_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  fmpf_pkg::cell_ctl_t ctl,
  input  fmpf_pkg::rule_t   load_rule,
  input  fmpf_pkg::rule_t   nb_rule,
  input  logic              nb_valid,
  input  fmpf_pkg::rule_t   query,
  input  logic [15:0]       query_id,
  output fmpf_pkg::rule_t   rule_q,
  output logic              valid_q,
  output logic              hit,
  output logic              id_hit
);
  import fmpf_pkg::*;

  rule_t rule_r;
  logic  valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      case (ctl.cmd)
        CELL_LOAD:  valid_r <= 1'b1;
        CELL_SHIFT: valid_r <= nb_valid;
        CELL_CLEAR: valid_r <= 1'b0;
        default:    valid_r <= valid_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CELL_LOAD:  rule_r <= load_rule;
      CELL_SHIFT: rule_r <= nb_rule;
      default:    rule_r <= rule_r;
    endcase
  end

  assign hit = valid_r && rule_r.enabled
             && (rule_r.sip_any || (rule_r.sip == query.sip))
             && (rule_r.dip_any || (rule_r.dip == query.dip))
             && ((rule_r.proto == 2'd0) || (rule_r.proto == query.proto))
             && ((rule_r.sport == 16'd0) || (rule_r.sport == query.sport))
             && ((rule_r.dport == 16'd0) || (rule_r.dport == query.dport));

  assign id_hit  = valid_r && (rule_r.id == query_id);
  assign rule_q  = rule_r;
  assign valid_q = valid_r;

endmodule

### rtl/first_match_packet_filter_core.sv
// ----------------------------------------------------------------------------
// first_match_packet_filter_core: ordered first-match rule table
// Usage:
//   in_*  : one command per transfer (check, add, remove, update, clear,
//           set next id); fields packed in in_tdata as listed at the port.
//   out_* : exactly one result per command, packed in out_tdata.
//   The rules sit in a chain of cells in table order. A command is captured
//   at its transfer, then every cell compares in parallel, a priority pick
//   finds the first hit, the table is updated (a remove shifts each cell
//   above the gap down by one) and the result is registered once the
//   output register is free, which raises out_tvalid.
//   No new command is taken until the captured one has executed.
//   A new command is taken while a result still waits on out_*. If the
//   receiver stalls, the captured command waits until the output register
//   frees, and in_tready stays low meanwhile.
//   Reset empties the table and sets the next id to 1; the block is ready
//   in the first cycle after reset.
// ----------------------------------------------------------------------------
module first_match_packet_filter_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // opcode[2:0], rule_id[18:3], src_ip[50:19], src_ip_any[51], dst_ip[83:52],
  // dst_ip_any[84], proto[86:85], src_port[102:87], dst_port[118:103],
  // allow_action[119], rule_enabled[120], zero fill [127:121]
  input  logic [fmpf_pkg::IN_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // status[1:0], allowed[2], matched[3], matched_rule_id[19:4],
  // assigned_id[35:20], zero fill [39:36]
  output logic [fmpf_pkg::OUT_W-1:0] out_tdata
);
  import fmpf_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic              state_r, state_nxt;
  logic [2:0]        op_r;
  logic [15:0]       qid_r;
  rule_t             query_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [15:0]       next_id_r, next_id_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;

  rule_t             cell_rule [MAX_RULES];
  logic [MAX_RULES-1:0] cell_valid, hit, id_hit, hit_first, id_first;
  cell_ctl_t         cell_ctl [MAX_RULES];
  rule_t             load_rule;

  logic              exec;
  logic              any_hit, any_id;
  logic [15:0]       hit_id;
  logic              hit_allow;
  logic [IDX_W-1:0]  id_idx;
  logic              full;

  logic [1:0]        o_status;
  logic              o_allowed, o_matched;
  logic [15:0]       o_mid, o_aid;

  assign in_tready = (state_r == ST_IDLE);
  assign exec      = (state_r == ST_EXEC) && (!out_valid_r || out_tready);
  assign full      = (count_r >= CNT_W'(MAX_RULES));

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r            <= in_tdata[2:0];
      qid_r           <= in_tdata[18:3];
      query_r.id      <= in_tdata[18:3];
      query_r.sip     <= in_tdata[50:19];
      query_r.sip_any <= in_tdata[51];
      query_r.dip     <= in_tdata[83:52];
      query_r.dip_any <= in_tdata[84];
      query_r.proto   <= in_tdata[86:85];
      query_r.sport   <= in_tdata[102:87];
      query_r.dport   <= in_tdata[118:103];
      query_r.allow   <= in_tdata[119];
      query_r.enabled <= in_tdata[120];
    end
  end

  genvar g;
  generate
    for (g = 0; g < MAX_RULES; g++) begin : g_cell
      rule_t nb_rule;
      logic  nb_valid;
      if (g == MAX_RULES - 1) begin : g_last
        assign nb_rule  = '0;
        assign nb_valid = 1'b0;
      end else begin : g_mid
        assign nb_rule  = cell_rule[g+1];
        assign nb_valid = cell_valid[g+1];
      end
      fmpf_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (cell_ctl[g]),
        .load_rule (load_rule),
        .nb_rule   (nb_rule),
        .nb_valid  (nb_valid),
        .query     (query_r),
        .query_id  (qid_r),
        .rule_q    (cell_rule[g]),
        .valid_q   (cell_valid[g]),
        .hit       (hit[g]),
        .id_hit    (id_hit[g])
      );
    end
  endgenerate

  // first set bit of each flag vector, one-hot
  always_comb begin
    logic seen_h, seen_i;
    seen_h = 1'b0;
    seen_i = 1'b0;
    for (int i = 0; i < MAX_RULES; i++) begin
      hit_first[i] = hit[i] && !seen_h;
      id_first[i]  = id_hit[i] && !seen_i;
      seen_h       = seen_h || hit[i];
      seen_i       = seen_i || id_hit[i];
    end
  end

  always_comb begin
    any_hit   = |hit;
    any_id    = |id_hit;
    hit_id    = '0;
    hit_allow = 1'b0;
    id_idx    = '0;
    for (int i = 0; i < MAX_RULES; i++) begin
      hit_id    = hit_id | ({16{hit_first[i]}} & cell_rule[i].id);
      hit_allow = hit_allow | (hit_first[i] & cell_rule[i].allow);
      id_idx    = id_idx | ({IDX_W{id_first[i]}} & IDX_W'(i));
    end
  end

  always_comb begin
    load_rule    = query_r;
    load_rule.id = (op_r == OP_ADD) ? next_id_r : qid_r;
  end

  always_comb begin
    for (int i = 0; i < MAX_RULES; i++) begin
      cell_ctl[i].cmd = CELL_HOLD;
      if (exec) begin
        case (op_r)
          OP_ADD: begin
            if (!full && (count_r == CNT_W'(i))) cell_ctl[i].cmd = CELL_LOAD;
          end
          OP_REMOVE: begin
            if (any_id && (IDX_W'(i) >= id_idx)) cell_ctl[i].cmd = CELL_SHIFT;
          end
          OP_UPDATE: begin
            if (id_first[i]) cell_ctl[i].cmd = CELL_LOAD;
          end
          OP_CLEAR: cell_ctl[i].cmd = CELL_CLEAR;
          default:  cell_ctl[i].cmd = CELL_HOLD;
        endcase
      end
    end
  end

  always_comb begin
    count_nxt   = count_r;
    next_id_nxt = next_id_r;
    o_status    = ST_OK;
    o_allowed   = 1'b0;
    o_matched   = 1'b0;
    o_mid       = '0;
    o_aid       = '0;
    case (op_r)
      OP_CHECK: begin
        o_matched = any_hit;
        o_allowed = any_hit ? hit_allow : 1'b1;
        o_mid     = hit_id;
      end
      OP_ADD: begin
        if (full) begin
          o_status = ST_FULL;
        end else begin
          count_nxt   = count_r + CNT_W'(1);
          next_id_nxt = next_id_r + 16'd1;
          o_aid       = next_id_r;
        end
      end
      OP_REMOVE: begin
        if (any_id) begin
          count_nxt = count_r - CNT_W'(1);
        end else begin
          o_status = ST_NOT_FOUND;
        end
      end
      OP_UPDATE: begin
        if (!any_id) o_status = ST_NOT_FOUND;
      end
      OP_CLEAR: begin
        count_nxt   = '0;
        next_id_nxt = ID_RESET;
      end
      OP_SETID: next_id_nxt = qid_r;
      default: ;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;
    if (state_r == ST_IDLE) begin
      if (in_tvalid) state_nxt = ST_EXEC;
    end else if (exec) begin
      state_nxt     = ST_IDLE;
      out_valid_nxt = 1'b1;
      out_data_nxt  = {4'd0, o_aid, o_mid, o_matched, o_allowed, o_status};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      next_id_r   <= ID_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec) begin
        count_r   <= count_nxt;
        next_id_r <= next_id_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### bench/fmpf_checker.sv
// ----------------------------------------------------------------------------
// fmpf_checker: result checker for the first-match packet filter
// Watches both stream channels, keeps its own copy of the rule table, predicts
// the result of each accepted command and compares every result transfer
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module fmpf_checker
  import fmpf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             out_tvalid,
  input  logic             out_tready,
  input  logic [OUT_W-1:0] out_tdata,
  output int               fail_count,
  output int               pending,
  output int               n_cmds,
  output int               n_matched,
  output int               n_full,
  output int               n_not_found
);

  typedef struct packed {
    logic [6:0]  pad;
    logic        enabled;
    logic        allow;
    logic [15:0] dport;
    logic [15:0] sport;
    logic [1:0]  proto;
    logic        dip_any;
    logic [31:0] dip;
    logic        sip_any;
    logic [31:0] sip;
    logic [15:0] rule_id;
    logic [2:0]  op;
  } cmd_t;

  typedef struct packed {
    logic [3:0]  pad;
    logic [15:0] assigned_id;
    logic [15:0] matched_rule_id;
    logic        matched;
    logic        allowed;
    logic [1:0]  status;
  } verdict_t;

  rule_t       rules [MAX_RULES];
  int          n_rules;
  logic [15:0] id_next;
  verdict_t    verdict_q [$];

  function automatic bit rule_hit(rule_t r, cmd_t c);
    return r.enabled && (r.sip_any || r.sip == c.sip) && (r.dip_any || r.dip == c.dip) &&
           (r.proto == 2'd0 || r.proto == c.proto) &&
           (r.sport == 16'd0 || r.sport == c.sport) &&
           (r.dport == 16'd0 || r.dport == c.dport);
  endfunction

  function automatic rule_t to_rule(cmd_t c, logic [15:0] id);
    rule_t r;
    r.id      = id;
    r.sip     = c.sip;
    r.sip_any = c.sip_any;
    r.dip     = c.dip;
    r.dip_any = c.dip_any;
    r.proto   = c.proto;
    r.sport   = c.sport;
    r.dport   = c.dport;
    r.allow   = c.allow;
    r.enabled = c.enabled;
    return r;
  endfunction

  function automatic int find_rule(logic [15:0] id);
    for (int i = 0; i < n_rules; i++) begin
      if (rules[i].id == id) return i;
    end
    return -1;
  endfunction

  // Applies one command to the table copy and returns its result.
  function automatic verdict_t classify_cmd(cmd_t c);
    verdict_t v;
    int       slot;
    v = '0;
    case (c.op)
      OP_CHECK: begin
        v.allowed = 1'b1;
        for (int i = 0; i < n_rules; i++) begin
          if (rule_hit(rules[i], c)) begin
            v.matched         = 1'b1;
            v.matched_rule_id = rules[i].id;
            v.allowed         = rules[i].allow;
            break;
          end
        end
      end
      OP_ADD: begin
        if (n_rules >= MAX_RULES) begin
          v.status = ST_FULL;
        end else begin
          rules[n_rules] = to_rule(c, id_next);
          n_rules++;
          v.assigned_id = id_next;
          id_next       = id_next + 16'd1;
        end
      end
      OP_REMOVE: begin
        slot = find_rule(c.rule_id);
        if (slot < 0) begin
          v.status = ST_NOT_FOUND;
        end else begin
          for (int i = slot; i + 1 < n_rules; i++) rules[i] = rules[i + 1];
          n_rules--;
        end
      end
      OP_UPDATE: begin
        slot = find_rule(c.rule_id);
        if (slot < 0) begin
          v.status = ST_NOT_FOUND;
        end else begin
          rules[slot] = to_rule(c, rules[slot].id);
        end
      end
      OP_CLEAR: begin
        n_rules = 0;
        id_next = ID_RESET;
      end
      OP_SETID: begin
        id_next = c.rule_id;
      end
      default: begin
      end
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    verdict_t got;
    if (!rst_n) begin
      n_rules = 0;
      id_next = ID_RESET;
      verdict_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (verdict_q.size() == 0) begin
          $error("result transfer with nothing outstanding: %h", out_tdata);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.allowed != want.allowed) begin
            $error("allowed: expected %0d, got %0d", want.allowed, got.allowed);
            fail_count++;
          end
          if (got.matched != want.matched) begin
            $error("matched: expected %0d, got %0d", want.matched, got.matched);
            fail_count++;
          end
          if (got.matched_rule_id != want.matched_rule_id) begin
            $error("matched_rule_id: expected %0d, got %0d", want.matched_rule_id,
                   got.matched_rule_id);
            fail_count++;
          end
          if (got.assigned_id != want.assigned_id) begin
            $error("assigned_id: expected %0d, got %0d", want.assigned_id,
                   got.assigned_id);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        want = classify_cmd(in_tdata);
        verdict_q.insert(verdict_q.size(), want);
        n_cmds++;
        if (want.matched) n_matched++;
        if (want.status == ST_FULL) n_full++;
        if (want.status == ST_NOT_FOUND) n_not_found++;
      end
    end
    pending = verdict_q.size();
  end

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for first_match_packet_filter_core
// Drives a directed command list and then random command streams rich in
// well-formed rule traffic, under varying source and sink throttling, a long
// sink hold-off and a drain pause; a checker module predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import fmpf_pkg::*;

  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 345;
  localparam int HOLD_CYCLES  = 60;

  typedef struct packed {
    logic [6:0]  pad;
    logic        enabled;
    logic        allow;
    logic [15:0] dport;
    logic [15:0] sport;
    logic [1:0]  proto;
    logic        dip_any;
    logic [31:0] dip;
    logic        sip_any;
    logic [31:0] sip;
    logic [15:0] rule_id;
    logic [2:0]  op;
  } cmd_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int rx_hold_req  = 0;
  int rx_hold_left = 0;
  int quiet_cycles = 0;
  int fail_count, pending, n_cmds, n_matched, n_full, n_not_found;

  cmd_t        rule_pool [$];
  logic [31:0] ip_pool [4] = '{32'h0A00_0001, 32'hC0A8_0101, 32'h0A00_0002, 32'hAC10_0005};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  first_match_packet_filter_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  fmpf_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending),
    .n_cmds     (n_cmds),
    .n_matched  (n_matched),
    .n_full     (n_full),
    .n_not_found(n_not_found)
  );

  // sink: random throttle, or a counted hold-off when requested
  always @(negedge clk) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic cmd_t make_cmd(input logic [2:0] op, input logic [15:0] id,
                                    input logic [31:0] sip, input logic sany,
                                    input logic [31:0] dip, input logic dany,
                                    input logic [1:0] proto, input logic [15:0] sport,
                                    input logic [15:0] dport, input logic allow,
                                    input logic en);
    cmd_t c;
    c         = '0;
    c.op      = op;
    c.rule_id = id;
    c.sip     = sip;
    c.sip_any = sany;
    c.dip     = dip;
    c.dip_any = dany;
    c.proto   = proto;
    c.sport   = sport;
    c.dport   = dport;
    c.allow   = allow;
    c.enabled = en;
    return c;
  endfunction

  function automatic logic [31:0] pick_ip();
    int r;
    r = $urandom_range(9);
    if (r < 7) return ip_pool[2'($urandom_range(3))];
    if (r == 7) return 32'h0;
    if (r == 8) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [15:0] pick_port();
    int r;
    r = $urandom_range(9);
    if (r < 4) return 16'd0;
    if (r == 4) return 16'd80;
    if (r == 5) return 16'd443;
    if (r == 6) return 16'd53;
    if (r == 7) return 16'hFFFF;
    return 16'($urandom_range(65535));
  endfunction

  function automatic logic [15:0] pick_id();
    int r;
    r = $urandom_range(9);
    if (r < 8) return 16'($urandom_range(20));
    if (r == 8) return 16'hFFFF;
    return 16'($urandom_range(65535));
  endfunction

  function automatic cmd_t rand_rule(input logic [2:0] op);
    return make_cmd(op, pick_id(), pick_ip(), $urandom_range(3) == 0, pick_ip(),
                    $urandom_range(3) == 0, 2'($urandom_range(3)), pick_port(),
                    pick_port(), 1'($urandom_range(1)), $urandom_range(9) != 0);
  endfunction

  // connection aimed at a recently added rule, sometimes nudged off it
  function automatic cmd_t aimed_check();
    cmd_t c;
    cmd_t p;
    p         = rule_pool[$urandom_range(rule_pool.size() - 1)];
    c         = p;
    c.op      = OP_CHECK;
    c.sip_any = 1'($urandom_range(1));
    c.dip_any = 1'($urandom_range(1));
    if (p.sip_any) c.sip = pick_ip();
    if (p.dip_any) c.dip = pick_ip();
    if (p.proto == 2'd0) c.proto = 2'($urandom_range(3));
    if (p.sport == 16'd0) c.sport = pick_port();
    if (p.dport == 16'd0) c.dport = pick_port();
    case ($urandom_range(7))
      0: c.sip[$urandom_range(31)] ^= 1'b1;
      1: c.dport ^= 16'd1;
      2: c.proto = 2'($urandom_range(3));
      default: begin
      end
    endcase
    return c;
  endfunction

  function automatic cmd_t rand_cmd();
    int   r;
    cmd_t c;
    r = $urandom_range(99);
    if (r < 35) begin
      if (rule_pool.size() > 0 && $urandom_range(9) < 7) c = aimed_check();
      else c = rand_rule(OP_CHECK);
    end else if (r < 70) begin
      c = rand_rule(OP_ADD);
    end else if (r < 80) begin
      c = rand_rule(OP_REMOVE);
    end else if (r < 88) begin
      c = rand_rule(OP_UPDATE);
    end else if (r < 89) begin
      c = rand_rule(OP_CLEAR);
    end else if (r < 93) begin
      c = rand_rule(OP_SETID);
      case ($urandom_range(5))
        0: c.rule_id = 16'd0;
        1: c.rule_id = 16'hFFFF;
        2: c.rule_id = 16'hFFFE;
        5: c.rule_id = 16'($urandom_range(65535));
        default: c.rule_id = 16'($urandom_range(1, 20));
      endcase
    end else if (r < 95) begin
      c = rand_rule($urandom_range(1) ? OP_RSVD6 : OP_RSVD7);
    end else begin
      c     = cmd_t'({$urandom, $urandom, $urandom, $urandom});
      c.pad = '0;
    end
    return c;
  endfunction

  task automatic send(input cmd_t c);
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    do @(posedge clk); while (!in_tready);
    if (c.op == OP_ADD) begin
      rule_pool.insert(rule_pool.size(), c);
      if (rule_pool.size() > MAX_RULES) void'(rule_pool.pop_front());
    end
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send(make_cmd(OP_CHECK, 16'd0, 32'h0A00_0001, 1'b0, 32'h0A00_0002, 1'b0, 2'd1,
                  16'd1000, 16'd80, 1'b0, 1'b0));
    send(make_cmd(OP_ADD, 16'hFFFF, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0, 2'd3,
                  16'hFFFF, 16'hFFFF, 1'b0, 1'b1));
    send(make_cmd(OP_ADD, 16'd0, 32'h0, 1'b1, 32'h0, 1'b1, 2'd0, 16'd0, 16'd0,
                  1'b0, 1'b0));
    send(make_cmd(OP_ADD, 16'd0, 32'h0A00_0001, 1'b0, 32'h0, 1'b1, 2'd1, 16'd0, 16'd80,
                  1'b1, 1'b1));
    send(make_cmd(OP_CHECK, 16'd0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0, 2'd3,
                  16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
    send(make_cmd(OP_CHECK, 16'd0, 32'h0A00_0001, 1'b0, 32'hC0A8_0101, 1'b0, 2'd1,
                  16'd5555, 16'd80, 1'b0, 1'b0));
    send(make_cmd(OP_CHECK, 16'd0, 32'h0A00_0001, 1'b0, 32'hC0A8_0101, 1'b0, 2'd2,
                  16'd5555, 16'd80, 1'b0, 1'b0));
    send(make_cmd(OP_UPDATE, 16'd2, 32'h0, 1'b1, 32'h0, 1'b1, 2'd0, 16'd0, 16'd0,
                  1'b0, 1'b1));
    send(make_cmd(OP_CHECK, 16'd0, 32'h0A00_0001, 1'b0, 32'hC0A8_0101, 1'b0, 2'd2,
                  16'd5555, 16'd80, 1'b0, 1'b0));
    send(make_cmd(OP_UPDATE, 16'd999, 32'h0, 1'b1, 32'h0, 1'b1, 2'd0, 16'd0, 16'd0,
                  1'b1, 1'b1));
    send(make_cmd(OP_REMOVE, 16'd999, 32'h0, 1'b0, 32'h0, 1'b0, 2'd0, 16'd0, 16'd0,
                  1'b0, 1'b0));
    send(make_cmd(OP_REMOVE, 16'd1, 32'h0, 1'b0, 32'h0, 1'b0, 2'd0, 16'd0, 16'd0,
                  1'b0, 1'b0));
    send(make_cmd(OP_CHECK, 16'd0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b0, 2'd3,
                  16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
    send(make_cmd(OP_SETID, 16'hFFFF, 32'h0, 1'b0, 32'h0, 1'b0, 2'd0, 16'd0, 16'd0,
                  1'b0, 1'b0));
    send(make_cmd(OP_ADD, 16'd0, 32'hAC10_0005, 1'b0, 32'h0, 1'b1, 2'd2, 16'd53, 16'd0,
                  1'b1, 1'b1));
    send(make_cmd(OP_ADD, 16'd0, 32'h0, 1'b1, 32'hAC10_0005, 1'b0, 2'd3, 16'd0, 16'd0,
                  1'b0, 1'b1));
    send(make_cmd(OP_SETID, 16'd3, 32'h0, 1'b0, 32'h0, 1'b0, 2'd0, 16'd0, 16'd0,
                  1'b0, 1'b0));
    send(make_cmd(OP_ADD, 16'd0, 32'hC0A8_0101, 1'b0, 32'h0A00_0002, 1'b0, 2'd1,
                  16'd443, 16'd443, 1'b0, 1'b1));
    send(make_cmd(OP_UPDATE, 16'd3, 32'h0A00_0002, 1'b0, 32'h0, 1'b1, 2'd0, 16'd0,
                  16'd22, 1'b1, 1'b1));
    send(make_cmd(OP_REMOVE, 16'd3, 32'h0, 1'b0, 32'h0, 1'b0, 2'd0, 16'd0, 16'd0,
                  1'b0, 1'b0));
    send(make_cmd(OP_RSVD6, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 2'd3,
                  16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
    send(make_cmd(OP_RSVD7, 16'd0, 32'h0, 1'b0, 32'h0, 1'b0, 2'd0, 16'd0, 16'd0,
                  1'b0, 1'b0));
    send(make_cmd(OP_CLEAR, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, 2'd3,
                  16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
    send(make_cmd(OP_ADD, 16'd0, 32'h0A00_0001, 1'b0, 32'h0A00_0002, 1'b0, 2'd0,
                  16'd0, 16'd0, 1'b0, 1'b1));
    send(make_cmd(OP_CHECK, 16'd0, 32'h0A00_0001, 1'b1, 32'h0A00_0002, 1'b1, 2'd2,
                  16'd7, 16'd9, 1'b1, 1'b1));
    wait (pending == 0);

    // long sink hold-off while the source keeps offering
    rx_hold_req = HOLD_CYCLES;
    repeat (12) send(rand_cmd());
    wait (pending == 0);

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 16 : (phase == 1) ? 54 : 0;
      rx_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 16 : 0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
        if (i == RANDOM_ITEMS / 2) wait (pending == 0);
        send(rand_cmd());
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (8) @(posedge clk);

    $display("summary: %0d commands, %0d checks hit a rule, %0d adds to a full table,",
             n_cmds, n_matched, n_full);
    $display("summary: %0d unknown ids, throttled both ways plus a %0d-cycle sink hold",
             n_not_found, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/fmpf_pkg.sv
rtl/fmpf_cell.sv
rtl/first_match_packet_filter_core.sv
bench/fmpf_checker.sv
bench/testbench.sv
